// ----- hw/rtl/sdls_pkg.sv -----
// ----------------------------------------------------------------------------
// sdls_pkg
// Shared widths, constants and types of the spectrum dB level smoother.
// ----------------------------------------------------------------------------
package sdls_pkg;

   // field widths
   localparam int BIN_W   = 9;
   localparam int PART_W  = 32;
   localparam int LVL_W   = 16;
   localparam int ALPHA_W = 16;

   // default store depth
   localparam int NUM_BINS_DEF = 512;

   // alpha after reset, 0.3 in Q0.16
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd19661;

   // log2 datapath
   localparam int PWR_W  = 64;
   localparam int MANT_W = 32;
   localparam int EXP_W  = 6;
   localparam int FRAC_W = 16;
   localparam int LOG_W  = EXP_W + FRAC_W;

   // 10*log10(2) * 655.35 in Q16
   localparam int SCALE_W = 27;
   localparam logic [SCALE_W-1:0] DB_SCALE = 27'd129289426;
   localparam int PROD_W = LOG_W + SCALE_W;

   // exponent of the 0 dB power
   localparam logic [EXP_W-1:0] ZERO_DB_EXP = 6'd48;

   localparam logic [LVL_W-1:0] LVL_MAX = 16'hFFFF;

   typedef logic [LVL_W-1:0] level_type;
   typedef logic [BIN_W-1:0] bin_type;

endpackage

// ----- hw/rtl/sdls_req_if.sv -----
// ----------------------------------------------------------------------------
// sdls_req_if
// Input channel: one spectrum bin (index and complex value) per transaction.
// ----------------------------------------------------------------------------
interface sdls_req_if import sdls_pkg::*; ();
   logic                     valid;
   logic                     ready;
   bin_type                  bin_index;
   logic signed [PART_W-1:0] real_part;
   logic signed [PART_W-1:0] imag_part;

   modport source (output valid, bin_index, real_part, imag_part, input ready);
   modport sink   (input valid, bin_index, real_part, imag_part, output ready);
endinterface

// ----- hw/rtl/sdls_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sdls_rsp_if
// Result channel: bin number, instant level and smoothed level.
// ----------------------------------------------------------------------------
interface sdls_rsp_if import sdls_pkg::*; ();
   logic      valid;
   logic      ready;
   bin_type   bin_number;
   level_type instant_level;
   level_type smoothed_level;

   modport source (output valid, bin_number, instant_level, smoothed_level,
                   input ready);
   modport sink   (input valid, bin_number, instant_level, smoothed_level,
                   output ready);
endinterface

// ----- hw/rtl/sdls_csr_if.sv -----
// ----------------------------------------------------------------------------
// sdls_csr_if
// Register write channel: new smoothing alpha per transaction.
// ----------------------------------------------------------------------------
interface sdls_csr_if import sdls_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ALPHA_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/spectrum_db_level_smoother.sv -----
// ----------------------------------------------------------------------------
// spectrum_db_level_smoother
// Power of each bin to a log level over -100..0 dB, blended per bin into a
// stored display level by exponential smoothing.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_if    in         valid/ready          bin_index, real_part, imag_part
//   rsp_if    out        valid/ready          bin_number, instant_level,
//                                             smoothed_level
//   csr_if    in         valid/ready (ready=1) data (smoothing alpha)
//
// one transaction per cycle sustained while rsp is ready; the pipeline depth is
// set by the 16 stages of mantissa squaring in log2 (one 32x32 multiplier each)
// plus power, normalize, scale and smoothing.
// after reset the level store is cleared entry by entry with req ready low.
// a stalled result freezes the whole pipeline; req ready follows rsp ready.
// same-bin updates in consecutive cycles are covered by a write-back bypass.
// ----------------------------------------------------------------------------
module spectrum_db_level_smoother
   import sdls_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sdls_req_if.sink   req_if,
   sdls_rsp_if.source rsp_if,
   sdls_csr_if.sink   csr_if
);

   localparam int AW   = $clog2(NUM_BINS);
   localparam int XW   = (AW > BIN_W) ? AW : BIN_W;
   localparam int SQ_N = FRAC_W;

   // stage positions
   localparam int S_ABS   = 0;
   localparam int S_SQR   = 1;
   localparam int S_PWR   = 2;
   localparam int S_LOD   = 3;
   localparam int S_EXP   = 4;
   localparam int S_NRM   = 5;
   localparam int S_LOGN  = S_NRM + SQ_N;
   localparam int S_BELOW = S_LOGN + 1;
   localparam int S_SCL   = S_BELOW + 1;
   localparam int S_LVL   = S_SCL + 1;
   localparam int S_SMT   = S_LVL + 1;
   localparam int S_OUT   = S_SMT + 1;
   localparam int NS      = S_OUT + 1;

   // highest set bit of a 16 bit chunk
   function automatic logic [3:0] lead16(input logic [15:0] v);
      logic [3:0] pos;
      pos = '0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) pos = 4'(i);
      end
      return pos;
   endfunction

   // bin number to store address
   function automatic logic [AW-1:0] bin_addr(input bin_type b);
      logic [XW-1:0] x;
      x = XW'(b);
      return x[AW-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // flow control
   // ---------------------------------------------------------------------
   logic          adv;
   logic          req_accept;
   logic [NS-1:0] v_ff;
   bin_type       idx_ff [NS];
   logic          clr_active_ff;
   logic [AW-1:0] clr_cnt_ff;

   assign adv          = !v_ff[S_OUT] || rsp_if.ready;
   assign req_if.ready = adv && !clr_active_ff;
   assign req_accept   = req_if.valid && req_if.ready;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], req_accept};
      end
   end

   // bin index travels with the item
   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff[0] <= req_if.bin_index;
         for (int k = 1; k < NS; k++) begin
            idx_ff[k] <= idx_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // alpha register
   // ---------------------------------------------------------------------
   logic [ALPHA_W-1:0] alpha_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else if (csr_if.valid) begin
         alpha_ff <= csr_if.data;
      end
   end

   // ---------------------------------------------------------------------
   // power: magnitudes, squares, sum
   // ---------------------------------------------------------------------
   logic [PART_W-1:0] re_abs_in, im_abs_in, re_abs_ff, im_abs_ff;
   logic [PWR_W-1:0]  re_sq_in, im_sq_in, re_sq_ff, im_sq_ff;
   logic [PWR_W-1:0]  pwr_in, pwr_ff;

   // most negative value maps to 2^31 by wrap-around
   assign re_abs_in = req_if.real_part[PART_W-1] ? (~req_if.real_part + 1'b1)
                                                 : req_if.real_part;
   assign im_abs_in = req_if.imag_part[PART_W-1] ? (~req_if.imag_part + 1'b1)
                                                 : req_if.imag_part;
   assign re_sq_in  = re_abs_ff * re_abs_ff;
   assign im_sq_in  = im_abs_ff * im_abs_ff;
   assign pwr_in    = re_sq_ff + im_sq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         re_abs_ff <= re_abs_in;
         im_abs_ff <= im_abs_in;
         re_sq_ff  <= re_sq_in;
         im_sq_ff  <= im_sq_in;
         pwr_ff    <= pwr_in;
      end
   end

   // ---------------------------------------------------------------------
   // leading one: per chunk, then across chunks, then normalize
   // ---------------------------------------------------------------------
   logic [3:0]       nz_in, nz_ff;
   logic [3:0]       pos_in [4];
   logic [3:0]       pos_ff [4];
   logic [PWR_W-1:0] pwr_lod_ff, pwr_exp_ff;
   logic [EXP_W-1:0] exp_in, exp_ff;
   logic             zero_in, zero_ff;
   logic [MANT_W-1:0] mant_nrm_in;
   logic [MANT_W-1:0] mant_in [1:SQ_N];
   logic [MANT_W-1:0] mant_ff [0:SQ_N];
   logic [EXP_W-1:0]  lexp_ff [0:SQ_N];
   logic              lzero_ff [0:SQ_N];
   logic [EXP_W-1:0]  sh_dn, sh_up;
   logic [PWR_W-1:0]  pwr_dn, pwr_up;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         nz_in[c]  = |pwr_ff[16*c +: 16];
         pos_in[c] = lead16(pwr_ff[16*c +: 16]);
      end
   end

   always_comb begin
      exp_in  = '0;
      zero_in = 1'b0;
      priority if (nz_ff[3]) exp_in = {2'd3, pos_ff[3]};
      else if (nz_ff[2])     exp_in = {2'd2, pos_ff[2]};
      else if (nz_ff[1])     exp_in = {2'd1, pos_ff[1]};
      else if (nz_ff[0])     exp_in = {2'd0, pos_ff[0]};
      else                   zero_in = 1'b1;
   end

   // mantissa as Q1.31 with the leading one at bit 31
   assign sh_dn       = exp_ff - EXP_W'(MANT_W - 1);
   assign sh_up       = EXP_W'(MANT_W - 1) - exp_ff;
   assign pwr_dn      = pwr_exp_ff >> sh_dn;
   assign pwr_up      = pwr_exp_ff << sh_up;
   assign mant_nrm_in = (exp_ff >= EXP_W'(MANT_W - 1)) ? pwr_dn[MANT_W-1:0]
                                                       : pwr_up[MANT_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         nz_ff       <= nz_in;
         pos_ff      <= pos_in;
         pwr_lod_ff  <= pwr_ff;
         pwr_exp_ff  <= pwr_lod_ff;
         exp_ff      <= exp_in;
         zero_ff     <= zero_in;
      end
   end

   // ---------------------------------------------------------------------
   // log2 fraction: one squaring of the mantissa per stage
   // ---------------------------------------------------------------------
   logic [FRAC_W-1:0] frac_in [1:SQ_N];
   logic [FRAC_W-1:0] frac_ff [1:SQ_N];
   logic              fbit   [1:SQ_N];

   always_comb begin
      logic [2*MANT_W-1:0] sqw;
      logic [MANT_W:0]     shw;
      for (int j = 1; j <= SQ_N; j++) begin
         sqw        = mant_ff[j-1] * mant_ff[j-1];
         shw        = sqw[2*MANT_W-1:MANT_W-1];
         fbit[j]    = shw[MANT_W];
         mant_in[j] = shw[MANT_W] ? shw[MANT_W:1] : shw[MANT_W-1:0];
      end
      frac_in[1] = FRAC_W'(fbit[1]);
      for (int j = 2; j <= SQ_N; j++) begin
         frac_in[j] = {frac_ff[j-1][FRAC_W-2:0], fbit[j]};
      end
   end

   // normalized entry stage, then the squaring stages
   always_ff @(posedge clock) begin
      if (adv) begin
         mant_ff[0]  <= mant_nrm_in;
         lexp_ff[0]  <= exp_ff;
         lzero_ff[0] <= zero_ff;
         for (int j = 1; j <= SQ_N; j++) begin
            mant_ff[j]  <= mant_in[j];
            frac_ff[j]  <= frac_in[j];
            lexp_ff[j]  <= lexp_ff[j-1];
            lzero_ff[j] <= lzero_ff[j-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // log to level: distance below 0 dB, scale, round, clamp
   // ---------------------------------------------------------------------
   logic [LOG_W-1:0]  log_val;
   logic [LOG_W-1:0]  below_in, below_ff;
   logic              sat_in, sat_ff, sat_scl_ff;
   logic              zero_blw_ff, zero_scl_ff;
   logic [PROD_W-1:0] prod_in, prod_ff;
   logic [PROD_W-1:0] prod_rnd;
   logic [LVL_W:0]    drop;
   level_type         lvl_in, lvl_ff, lvl_smt_ff;

   assign log_val  = {lexp_ff[SQ_N], frac_ff[SQ_N]};
   assign sat_in   = lexp_ff[SQ_N] >= ZERO_DB_EXP;
   assign below_in = {ZERO_DB_EXP, FRAC_W'(0)} - log_val;
   assign prod_in  = below_ff * DB_SCALE;
   assign prod_rnd = prod_ff + (PROD_W'(1) << 31);
   assign drop     = prod_rnd[LVL_W+32:32];

   // zero power first, then at or above 0 dB, then below -100 dB
   always_comb begin
      priority if (zero_scl_ff)             lvl_in = '0;
      else if (sat_scl_ff)                  lvl_in = LVL_MAX;
      else if (drop >= {1'b0, LVL_MAX})     lvl_in = '0;
      else                                  lvl_in = LVL_W'({1'b0, LVL_MAX} - drop);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         below_ff    <= below_in;
         sat_ff      <= sat_in;
         zero_blw_ff <= lzero_ff[SQ_N];
         prod_ff     <= prod_in;
         sat_scl_ff  <= sat_ff;
         zero_scl_ff <= zero_blw_ff;
         lvl_ff      <= lvl_in;
         lvl_smt_ff  <= lvl_ff;
      end
   end

   // ---------------------------------------------------------------------
   // level store with clearing pass and write-back bypass
   // ---------------------------------------------------------------------
   level_type     lvl_mem [NUM_BINS];
   level_type     rd_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   level_type     wr_data;
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   level_type     fwd_data_ff;
   logic          in_range;
   logic          item_wr;
   logic [AW-1:0] smt_addr;
   level_type     old_lvl;
   level_type     smooth_in;

   assign in_range = 32'(idx_ff[S_SMT]) < NUM_BINS;
   assign smt_addr = bin_addr(idx_ff[S_SMT]);
   assign item_wr  = adv && v_ff[S_SMT] && in_range;
   assign wr_en    = clr_active_ff || item_wr;
   assign wr_addr  = clr_active_ff ? clr_cnt_ff : smt_addr;
   assign wr_data  = clr_active_ff ? '0 : smooth_in;

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else if (clr_active_ff) begin
         if (clr_cnt_ff == AW'(NUM_BINS - 1)) clr_active_ff <= 1'b0;
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) lvl_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (adv) rd_ff <= lvl_mem[bin_addr(idx_ff[S_LVL])];
   end

   // last written entry, covers a read that raced its write
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (clr_active_ff) begin
         fwd_valid_ff <= 1'b0;
      end else if (item_wr) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (item_wr) begin
         fwd_addr_ff <= smt_addr;
         fwd_data_ff <= smooth_in;
      end
   end

   assign old_lvl = (fwd_valid_ff && fwd_addr_ff == smt_addr) ? fwd_data_ff : rd_ff;

   // ---------------------------------------------------------------------
   // smoothing: old + alpha*(new - old), rounded
   // ---------------------------------------------------------------------
   logic signed [LVL_W:0]     delta;
   logic signed [2*LVL_W+1:0] wprod;
   logic signed [2*LVL_W+1:0] acc;

   assign delta     = $signed({1'b0, lvl_smt_ff}) - $signed({1'b0, old_lvl});
   assign wprod     = $signed({1'b0, alpha_ff}) * delta;
   assign acc       = $signed({2'b00, old_lvl, LVL_W'(0)}) + wprod
                      + $signed((2*LVL_W+2)'(1) << (LVL_W - 1));
   assign smooth_in = acc[2*LVL_W-1:LVL_W];

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   level_type inst_out_ff, smooth_out_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         inst_out_ff   <= lvl_smt_ff;
         smooth_out_ff <= in_range ? smooth_in : '0;
      end
   end

   assign rsp_if.valid          = v_ff[S_OUT];
   assign rsp_if.bin_number     = idx_ff[S_OUT];
   assign rsp_if.instant_level  = inst_out_ff;
   assign rsp_if.smoothed_level = smooth_out_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_clear_empty : assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> (v_ff == '0))
      else $error("pipeline holds items during store clearing");

   a_clear_block : assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req_if.ready)
      else $error("input taken during store clearing");

   a_alpha_zero : assert property (@(posedge clock) disable iff (reset)
      (v_ff[S_SMT] && alpha_ff == '0 && in_range) |-> (smooth_in == old_lvl))
      else $error("zero alpha changed a stored level");

   a_out_of_range : assert property (@(posedge clock) disable iff (reset)
      (adv && v_ff[S_SMT] && !in_range) |=> (rsp_if.smoothed_level == '0))
      else $error("bin beyond store gave a nonzero smoothed level");

endmodule

// ----- tb/tb_spectrum_db_level_smoother.sv -----
// ----------------------------------------------------------------------------
// tb_spectrum_db_level_smoother
// Self-checking bench for the spectrum dB level smoother. A queue-fed driver
// sends spectrum bins. A shadow copy of the power-to-dB mapping and of the
// per-bin smoothing store predicts every result. A monitor checks each
// result, field by field, in arrival order. Alpha is rewritten between
// phases, once the pipeline has drained, and its extremes are covered.
// ----------------------------------------------------------------------------
module tb_spectrum_db_level_smoother;
   import sdls_pkg::*;

   localparam int NUM_BINS   = NUM_BINS_DEF;
   localparam int MAX_GAP    = 17;
   localparam int TAIL_WAIT  = 60;
   localparam int PHASE_LEN  = 265;
   localparam int NUM_PHASES = 7;

   typedef struct {
      bin_type                  bin;
      logic signed [PART_W-1:0] re;
      logic signed [PART_W-1:0] im;
   } bin_sample_t;

   typedef struct {
      bin_type   bin;
      level_type instant;
      level_type smoothed;
   } level_result_t;

   logic clock;
   logic reset;

   sdls_req_if req_ch ();
   sdls_rsp_if rsp_ch ();
   sdls_csr_if csr_ch ();

   spectrum_db_level_smoother dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // shadow state of the block
   level_type          shadow_levels [NUM_BINS];
   logic [ALPHA_W-1:0] shadow_alpha;

   bin_sample_t   sample_q [$];
   level_result_t pending_levels [$];

   bin_sample_t cur_sample;
   bit          req_busy;
   bit          req_taken;
   bit          rsp_taken;
   bit          req_calm;
   bit          rsp_calm;
   bit          burst_only;
   int          req_wait;
   int          rsp_stall;

   int errors;
   int bins_sent;
   int results_seen;
   int floor_hits;
   int full_hits;
   int alpha_writes;
   bin_type last_bin;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // magnitude of a two's complement part, 2^31 kept exact
   function automatic logic [PART_W-1:0] part_magnitude(logic signed [PART_W-1:0] v);
      logic [PART_W-1:0] u;
      u = v;
      return u[PART_W-1] ? (~u + 32'd1) : u;
   endfunction

   // log2 in Q6.16: leading one, then fraction bits by squaring the mantissa
   function automatic logic [LOG_W-1:0] power_log2(logic [PWR_W-1:0] pwr);
      int unsigned      lead;
      logic [63:0]      mant;
      logic [FRAC_W-1:0] frac;
      lead = 63;
      while (lead > 0 && !pwr[lead])
         lead--;
      if (lead >= 31)
         mant = pwr >> (lead - 31);
      else
         mant = pwr << (31 - lead);
      frac = '0;
      for (int i = 0; i < FRAC_W; i++) begin
         mant = (mant * mant) >> 31;
         frac = frac << 1;
         if (mant >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            mant    = mant >> 1;
         end
      end
      return {lead[EXP_W-1:0], frac};
   endfunction

   // power to 0..65535 level over -100..0 dB, clamped at both ends
   function automatic level_type power_level(logic [PWR_W-1:0] pwr);
      logic [LOG_W-1:0] lg;
      logic [63:0]      below;
      logic [63:0]      drop;
      if (pwr == '0)
         return '0;
      lg = power_log2(pwr);
      if (lg >= {ZERO_DB_EXP, 16'h0000})
         return LVL_MAX;
      below = 64'({ZERO_DB_EXP, 16'h0000}) - 64'(lg);
      drop  = (below * 64'(DB_SCALE) + 64'h8000_0000) >> 32;
      if (drop >= 64'(LVL_MAX))
         return '0;
      return LVL_MAX - drop[LVL_W-1:0];
   endfunction

   // gap length for one transaction
   function automatic int gap_draw(bit calm);
      if (calm || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // random part: zero, full random, extremes or log-uniform magnitude
   function automatic logic signed [PART_W-1:0] random_part();
      logic [PART_W-1:0] v;
      int                pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            v = '0;
         end
         1: begin
            v = $urandom;
         end
         2: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'h0100_0000;
               default: v = 32'hFF00_0000;
            endcase
         end
         default: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1))
               v = ~v + 32'd1;
         end
      endcase
      return v;
   endfunction

   task automatic queue_bin(bin_type bin, logic [PART_W-1:0] re, logic [PART_W-1:0] im);
      bin_sample_t s;
      s.bin = bin;
      s.re  = re;
      s.im  = im;
      sample_q.push_back(s);
   endtask

   task automatic queue_random_bin();
      bin_type bin;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         bin = bin_type'($urandom_range(0, 7));
      else if (pick < 88)
         bin = bin_type'($urandom_range(0, NUM_BINS - 1));
      else
         bin = last_bin;
      last_bin = bin;
      queue_bin(bin, random_part(), random_part());
   endtask

   // hold off until every queued bin has been sent and every result checked
   task automatic wait_drained();
      do
         @(negedge clock);
      while (sample_q.size() != 0 || req_busy || pending_levels.size() != 0);
   endtask

   task automatic write_alpha(logic [ALPHA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      forever begin
         @(posedge clock);
         if (csr_ch.ready)
            break;
      end
      shadow_alpha = value;
      alpha_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic check_field(string name, int want, int got, bin_type bin);
      if (want != got) begin
         errors++;
         $display("%0t: bin %0d %s expected %0d actual %0d", $time, bin, name, want, got);
      end
   endtask

   // input transaction taken: predict its result
   always @(posedge clock) begin : req_accept
      logic [PWR_W-1:0] ra;
      logic [PWR_W-1:0] ia;
      logic [PWR_W-1:0] pwr;
      logic [63:0]      acc;
      level_result_t    res;
      if (!reset && req_ch.valid && req_ch.ready) begin
         ra  = 64'(part_magnitude(cur_sample.re));
         ia  = 64'(part_magnitude(cur_sample.im));
         pwr = ra * ra + ia * ia;
         res.bin      = cur_sample.bin;
         res.instant  = power_level(pwr);
         res.smoothed = '0;
         if (int'(cur_sample.bin) < NUM_BINS) begin
            acc = 64'(shadow_levels[cur_sample.bin]) * (64'd65536 - 64'(shadow_alpha))
                + 64'(shadow_alpha) * 64'(res.instant) + 64'd32768;
            res.smoothed = acc[31:16];
            shadow_levels[cur_sample.bin] = res.smoothed;
         end
         pending_levels.push_back(res);
         bins_sent++;
         req_taken = 1'b1;
      end
   end

   // bin driver, fed from the sample queue
   always @(negedge clock) begin : req_driver
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_busy  = 1'b0;
            if ($urandom_range(0, 63) == 0)
               req_calm = !req_calm;
            req_wait = gap_draw(req_calm || burst_only);
         end
         if (!req_busy) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (sample_q.size() > 0) begin
               cur_sample = sample_q.pop_front();
               req_busy   = 1'b1;
               req_ch.bin_index <= cur_sample.bin;
               req_ch.real_part <= cur_sample.re;
               req_ch.imag_part <= cur_sample.im;
            end
         end
         req_ch.valid <= req_busy;
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      level_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         rsp_taken = 1'b1;
         if (rsp_ch.instant_level == '0)
            floor_hits++;
         if (rsp_ch.instant_level == LVL_MAX)
            full_hits++;
         if (pending_levels.size() == 0) begin
            errors++;
            $display("%0t: result for bin %0d with no transaction pending, expected none",
                     $time, rsp_ch.bin_number);
         end else begin
            want = pending_levels.pop_front();
            check_field("bin_number", int'(want.bin), int'(rsp_ch.bin_number), want.bin);
            check_field("instant_level", int'(want.instant), int'(rsp_ch.instant_level),
                        want.bin);
            check_field("smoothed_level", int'(want.smoothed), int'(rsp_ch.smoothed_level),
                        want.bin);
         end
      end
   end

   // result backpressure
   always @(negedge clock) begin : rsp_ready_gen
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         if ($urandom_range(0, 63) == 0)
            rsp_calm = !rsp_calm;
         rsp_stall = gap_draw(rsp_calm);
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // run limit
   initial begin
      #4_000_000;
      $display("%0t: run limit reached, %0d results still pending", $time,
               pending_levels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // stimulus and end of run
   initial begin
      logic [ALPHA_W-1:0] phase_alpha [NUM_PHASES];
      req_ch.valid     = 1'b0;
      req_ch.bin_index = '0;
      req_ch.real_part = '0;
      req_ch.imag_part = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.data      = '0;
      reset            = 1'b1;
      req_busy = 0; req_taken = 0; rsp_taken = 0;
      req_calm = 0; rsp_calm = 0; burst_only = 1;
      req_wait = 0; rsp_stall = 0;
      errors = 0; bins_sent = 0; results_seen = 0;
      floor_hits = 0; full_hits = 0; alpha_writes = 0; last_bin = '0;
      shadow_alpha = ALPHA_RESET;
      foreach (shadow_levels[i])
         shadow_levels[i] = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed bins at the reset alpha, sent back to back
      queue_bin(9'd0,   32'h0000_0000, 32'h0000_0000);   // zero power
      queue_bin(9'd511, 32'h0100_0000, 32'h0000_0000);   // exactly 0 dB
      queue_bin(9'd1,   32'h7FFF_FFFF, 32'h7FFF_FFFF);   // above 0 dB
      queue_bin(9'd2,   32'h8000_0000, 32'h8000_0000);   // most negative parts
      queue_bin(9'd3,   32'h8000_0000, 32'h0000_0000);
      queue_bin(9'd4,   32'h0000_0000, 32'h8000_0000);
      queue_bin(9'd5,   32'h0000_0001, 32'h0000_0000);   // smallest power
      queue_bin(9'd6,   32'h0000_00A8, 32'h0000_0000);   // near -100 dB
      queue_bin(9'd6,   32'h0000_00A7, 32'h0000_0000);
      queue_bin(9'd7,   32'hFF00_0000, 32'h0000_0000);
      queue_bin(9'd7,   32'h0000_0000, 32'hFF00_0000);
      queue_bin(9'd8,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_bin(9'd9,   32'h00FF_FFFF, 32'h0000_0000);   // just under 0 dB
      queue_bin(9'd10,  32'h0010_0000, 32'h0010_0000);
      // same bin in consecutive transactions, through the write-back bypass
      repeat (6)
         queue_bin(9'd12, 32'h0100_0000, 32'h0000_0000);
      queue_bin(9'd12,  32'h0000_0000, 32'h0000_0000);
      queue_bin(9'd13,  32'h7FFF_FFFF, 32'h8000_0000);
      queue_bin(9'd511, 32'h0000_0000, 32'h0000_0000);
      queue_bin(9'd0,   32'h0100_0000, 32'h0100_0000);
      wait_drained();
      burst_only = 0;

      // random phases, one alpha each, extremes included
      phase_alpha[0] = 16'hFFFF;
      phase_alpha[1] = 16'h0000;
      phase_alpha[2] = 16'h0001;
      phase_alpha[3] = 16'h8000;
      phase_alpha[4] = ALPHA_W'($urandom);
      phase_alpha[5] = 16'hFFFE;
      phase_alpha[6] = ALPHA_W'($urandom);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_alpha(phase_alpha[ph]);
         repeat (PHASE_LEN)
            queue_random_bin();
         wait_drained();
      end

      // catch any stray result
      repeat (TAIL_WAIT) @(negedge clock);

      $display("covered %0d bin transactions over %0d alpha settings plus reset default",
               bins_sent, alpha_writes);
      $display("levels seen: %0d at floor, %0d at full scale, %0d mismatches",
               floor_hits, full_hits, errors);
      if (errors == 0 && pending_levels.size() == 0 && results_seen == bins_sent)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
